>>> hw/rtl/pfm_pkg.sv
// Shared widths, request codes and status codes of the page frame mapper.
package pfm_pkg;

  localparam int SEC_W        = 10;
  localparam int HINT_W       = 16;
  localparam int REQ_W        = 2;
  localparam int ST_W         = 3;
  localparam int OUT_FRM_W    = 5;
  localparam int SCAN_CHUNK   = 32;

  typedef logic [REQ_W-1:0] req_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam req_t REQ_LOOKUP  = 2'd0;
  localparam req_t REQ_REPLACE = 2'd1;
  localparam req_t REQ_FREE    = 2'd2;

  localparam status_t ST_HIT      = 3'd0;
  localparam status_t ST_ALLOC    = 3'd1;
  localparam status_t ST_FAULT    = 3'd2;
  localparam status_t ST_REPLACED = 3'd3;
  localparam status_t ST_FREED    = 3'd4;
  localparam status_t ST_IGNORED  = 3'd5;

endpackage

>>> hw/rtl/pfm_mod_unit.sv
// Reciprocal-multiply unit reducing the victim hint modulo the frame count, in quotient, remainder and fix phases.
module pfm_mod_unit #(
  parameter int NUM_FRAMES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pfm_pkg::HINT_W-1:0]  hint,
  output logic                        busy,
  output logic [((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)-1:0] rem
);
  import pfm_pkg::*;

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int NW = FW + 1;
  localparam int PW = HINT_W + 32;
  localparam int BW = HINT_W + NW;
  localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / NUM_FRAMES);
  localparam logic [NW-1:0] MODV  = NW'(NUM_FRAMES);

  localparam logic [1:0] P_QUOT = 2'd0;
  localparam logic [1:0] P_REM  = 2'd1;
  localparam logic [1:0] P_FIX  = 2'd2;

  logic [HINT_W-1:0] hint_r;
  logic [PW-1:0]     prod_r;
  logic [HINT_W-1:0] quot;
  logic [BW-1:0]     back;
  logic [BW-1:0]     diff;
  logic [NW-1:0]     rest_r;
  logic [FW-1:0]     rem_r;
  logic [1:0]        phase_r;
  logic              busy_r;

  // quotient estimate is exact or one low; one compare-subtract settles it
  assign quot = prod_r[PW-1:32];
  assign back = BW'(quot) * BW'(MODV);
  assign diff = BW'(hint_r) - back;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= P_QUOT;
    end else if (start) begin
      busy_r  <= 1'b1;
      phase_r <= P_QUOT;
    end else if (busy_r) begin
      unique case (phase_r)
        P_QUOT: begin
          phase_r <= P_REM;
        end
        P_REM: begin
          phase_r <= P_FIX;
        end
        default: begin
          phase_r <= P_QUOT;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hint_r <= hint;
    end else if (busy_r) begin
      unique case (phase_r)
        P_QUOT: begin
          prod_r <= PW'(hint_r) * PW'(RECIP);
        end
        P_REM: begin
          rest_r <= NW'(diff);
        end
        default: begin
          rem_r <= (rest_r >= MODV) ? FW'(rest_r - MODV) : FW'(rest_r);
        end
      endcase
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

>>> hw/rtl/pfm_free_scan.sv
// Chunked search for the lowest free frame, one chunk of used flags per cycle.
module pfm_free_scan #(
  parameter int NUM_FRAMES = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [NUM_FRAMES-1:0] used,
  output logic                  busy,
  output logic                  found,
  output logic [((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)-1:0] frame
);
  import pfm_pkg::*;

  localparam int FW     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CHUNK  = (NUM_FRAMES < SCAN_CHUNK) ? NUM_FRAMES : SCAN_CHUNK;
  localparam int NCHUNK = (NUM_FRAMES + CHUNK - 1) / CHUNK;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PW     = (CHUNK > 1) ? $clog2(CHUNK) : 1;
  localparam int PADW   = NCHUNK * CHUNK;

  logic [PADW-1:0]  used_pad;
  logic [CHUNK-1:0] chunk;
  logic             hit;
  logic [PW-1:0]    pos;
  logic [FW-1:0]    idx;
  logic             last;
  logic [CW-1:0]    c_r;
  logic             busy_r;
  logic             found_r;
  logic [FW-1:0]    frame_r;

  if (PADW > NUM_FRAMES) begin : g_pad
    assign used_pad = {{(PADW - NUM_FRAMES){1'b1}}, used};
  end else begin : g_nopad
    assign used_pad = used;
  end

  assign chunk = used_pad[c_r * CHUNK +: CHUNK];
  assign last  = (c_r == CW'(NCHUNK - 1));

  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int k = CHUNK - 1; k >= 0; k--) begin
      if (!chunk[k]) begin
        hit = 1'b1;
        pos = PW'(k);
      end
    end
  end

  assign idx = FW'(16'(c_r) * 16'(CHUNK) + 16'(pos));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      c_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      c_r    <= '0;
    end else if (busy_r) begin
      if (hit || last) begin
        busy_r <= 1'b0;
      end else begin
        c_r <= c_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && (hit || last)) begin
      found_r <= hit;
      frame_r <= idx;
    end
  end

  assign busy  = busy_r;
  assign found = found_r;
  assign frame = frame_r;

endmodule

>>> hw/rtl/page_frame_mapper_core.sv
// Page frame mapper top level: request sequencer, frame and sector tables.
// Path: hit/free S_RD, S_DEC, S_DONE; rejected S_RD, S_DONE; replace adds S_MOD (modulo unit),
//   S_VRD, S_EVICT, S_MAP; allocate adds S_SCAN (free-frame scan), and S_MAP if a frame is free.
// Throughput: one request at a time; the next can be taken once the result is registered,
//   while that result may still wait on out_tready.
// Reset: synchronous, active low; sector table then swept over all NUM_SECTORS entries, in_tready low.
module page_frame_mapper_core #(
  parameter int NUM_FRAMES  = 32,
  parameter int NUM_SECTORS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // sector[9:0], victim_hint[25:10], zero pad
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // frame[4:0], writeback_sector[14:5], zero pad
  output logic [3:0]  out_tuser   // status[2:0], writeback_valid[3]
);
  import pfm_pkg::*;

  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int SW = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_MOD   = 4'd4;
  localparam logic [3:0] S_VRD   = 4'd5;
  localparam logic [3:0] S_EVICT = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_MAP   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]            state_r, state_nxt;
  logic [SW-1:0]         clr_idx_r, clr_idx_nxt;
  req_t                  req_r;
  logic [SEC_W-1:0]      sec_r;
  logic [HINT_W-1:0]     hint_r;
  logic [FW-1:0]         res_frm_r, res_frm_nxt;
  status_t               res_st_r, res_st_nxt;
  logic [SEC_W-1:0]      res_wb_sec_r, res_wb_sec_nxt;
  logic                  res_wb_ok_r, res_wb_ok_nxt;
  logic [NUM_FRAMES-1:0] frame_used_r, frame_used_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_load;
  logic [OUT_FRM_W-1:0]  out_frame_r;
  status_t               out_status_r;
  logic [SEC_W-1:0]      out_wb_sec_r;
  logic                  out_wb_ok_r;

  logic [FW:0]           sec_mem [NUM_SECTORS];
  logic [FW:0]           loc_q;
  logic                  sec_we;
  logic [SW-1:0]         sec_wa;
  logic [FW:0]           sec_wd;
  logic [SW-1:0]         sec_idx;

  logic [SEC_W-1:0]      owner_mem [NUM_FRAMES];
  logic [SEC_W-1:0]      owner_q;
  logic                  owner_we;

  logic                  in_range;
  logic                  loc_mapped;
  logic [FW-1:0]         loc_frm;
  logic                  mod_start;
  logic                  mod_busy;
  logic [FW-1:0]         mod_rem;
  logic                  scan_start;
  logic                  scan_busy;
  logic                  scan_found;
  logic [FW-1:0]         scan_frame;
  logic                  in_acc;

  assign in_acc     = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign sec_idx    = SW'(sec_r);
  assign in_range   = (17'(sec_r) < 17'(NUM_SECTORS));
  assign loc_mapped = loc_q[FW];
  assign loc_frm    = loc_q[FW-1:0];
  assign mod_start  = (state_r == S_RD) && in_range && (req_r == REQ_REPLACE);
  assign scan_start = (state_r == S_DEC) && (req_r == REQ_LOOKUP) && !loc_mapped;
  assign owner_we   = (state_r == S_MAP);

  pfm_mod_unit #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .hint  (hint_r),
    .busy  (mod_busy),
    .rem   (mod_rem)
  );

  pfm_free_scan #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .used  (frame_used_r),
    .busy  (scan_busy),
    .found (scan_found),
    .frame (scan_frame)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    res_frm_nxt    = res_frm_r;
    res_st_nxt     = res_st_r;
    res_wb_sec_nxt = res_wb_sec_r;
    res_wb_ok_nxt  = res_wb_ok_r;
    frame_used_nxt = frame_used_r;
    out_load       = 1'b0;
    sec_we         = 1'b0;
    sec_wa         = sec_idx;
    sec_wd         = '0;
    unique case (state_r)
      S_CLEAR: begin
        sec_we = 1'b1;
        sec_wa = clr_idx_r;
        if (clr_idx_r == SW'(NUM_SECTORS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        res_frm_nxt    = '0;
        res_wb_sec_nxt = '0;
        res_wb_ok_nxt  = 1'b0;
        res_st_nxt     = ST_FAULT;
        if (!in_range) begin
          res_st_nxt = (req_r == REQ_FREE) ? ST_IGNORED : ST_FAULT;
          state_nxt  = S_DONE;
        end else if (req_r == REQ_LOOKUP || req_r == REQ_REPLACE || req_r == REQ_FREE) begin
          state_nxt = S_DEC;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DEC: begin
        state_nxt = S_DONE;
        if (req_r == REQ_FREE) begin
          if (loc_mapped) begin
            sec_we                  = 1'b1;
            frame_used_nxt[loc_frm] = 1'b0;
            res_frm_nxt             = loc_frm;
            res_st_nxt              = ST_FREED;
          end else begin
            res_st_nxt = ST_IGNORED;
          end
        end else if (loc_mapped) begin
          res_frm_nxt = loc_frm;
          res_st_nxt  = ST_HIT;
        end else if (req_r == REQ_LOOKUP) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (!mod_busy) begin
          res_frm_nxt = mod_rem;
          state_nxt   = S_VRD;
        end
      end
      S_VRD: begin
        state_nxt = S_EVICT;
      end
      S_EVICT: begin
        res_st_nxt = ST_REPLACED;
        if (frame_used_r[res_frm_r]) begin
          sec_we         = 1'b1;
          sec_wa         = SW'(owner_q);
          res_wb_sec_nxt = owner_q;
          res_wb_ok_nxt  = 1'b1;
        end
        state_nxt = S_MAP;
      end
      S_SCAN: begin
        if (!scan_busy) begin
          if (scan_found) begin
            res_frm_nxt = scan_frame;
            res_st_nxt  = ST_ALLOC;
            state_nxt   = S_MAP;
          end else begin
            res_st_nxt = ST_FAULT;
            state_nxt  = S_DONE;
          end
        end
      end
      S_MAP: begin
        sec_we                    = 1'b1;
        sec_wd                    = {1'b1, res_frm_r};
        frame_used_nxt[res_frm_r] = 1'b1;
        state_nxt                 = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      frame_used_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      frame_used_r <= frame_used_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_tuser;
      sec_r  <= in_tdata[SEC_W-1:0];
      hint_r <= in_tdata[SEC_W+HINT_W-1:SEC_W];
    end
    res_frm_r    <= res_frm_nxt;
    res_st_r     <= res_st_nxt;
    res_wb_sec_r <= res_wb_sec_nxt;
    res_wb_ok_r  <= res_wb_ok_nxt;
    if (out_load) begin
      out_frame_r  <= OUT_FRM_W'(res_frm_r);
      out_status_r <= res_st_r;
      out_wb_sec_r <= res_wb_sec_r;
      out_wb_ok_r  <= res_wb_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sec_we) begin
      sec_mem[sec_wa] <= sec_wd;
    end
    loc_q <= sec_mem[sec_idx];
  end

  always_ff @(posedge clk) begin
    if (owner_we) begin
      owner_mem[res_frm_r] <= sec_r;
    end
    owner_q <= owner_mem[res_frm_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_wb_sec_r, out_frame_r};
  assign out_tuser  = {out_wb_ok_r, out_status_r};

`ifndef SYNTHESIS
  a_wb_only_on_replace: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[3]) |-> (out_tuser[2:0] == ST_REPLACED))
    else $error("write-back flagged on a non-replace result");

  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[2:0] <= ST_IGNORED))
    else $error("result status outside the defined codes");

  a_map_sets_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAP) |=> frame_used_r[$past(res_frm_r)])
    else $error("mapped frame not marked used");
`endif

endmodule

>>> tb/sv/tb.sv
// Testbench for the page frame mapper core: a directed table, then random traffic checked against a table predictor.
module tb;
  import pfm_pkg::*;

  localparam int FRAMES  = 32;
  localparam int SECTORS = 1024;
  localparam req_t REQ_UNUSED = 2'd3;
  localparam int DIR_ROWS = 23;
  localparam int PHASE_ITEMS = 240;

  typedef struct packed {
    logic [OUT_FRM_W-1:0] frame;
    status_t              status;
    logic [SEC_W-1:0]     wb_sector;
    logic                 wb_valid;
  } page_result_t;

  typedef struct {
    req_t              req;
    logic [SEC_W-1:0]  sector;
    logic [HINT_W-1:0] hint;
    bit                typed;
    page_result_t      want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;
  logic [1:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [15:0]       out_tdata;
  logic [3:0]        out_tuser;

  // predictor state
  bit                frm_used   [FRAMES];
  logic [SEC_W-1:0]  frm_sector [FRAMES];
  bit                sec_mapped [SECTORS];
  logic [4:0]        sec_frame  [SECTORS];

  page_result_t      pending_results [$];
  int                fail_count = 0;
  int                status_seen [8];
  int                wb_seen = 0;
  int                src_idle_pct = 0;
  int                sink_stall_pct = 0;
  dir_row_t          dir_table [DIR_ROWS];

  page_frame_mapper_core #(
    .NUM_FRAMES (FRAMES),
    .NUM_SECTORS(SECTORS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  function automatic void link_pair(int f, logic [SEC_W-1:0] s);
    frm_used[f]   = 1'b1;
    frm_sector[f] = s;
    sec_mapped[s] = 1'b1;
    sec_frame[s]  = f[4:0];
  endfunction

  function automatic page_result_t map_request(req_t r, logic [SEC_W-1:0] s,
                                               logic [HINT_W-1:0] h);
    page_result_t res;
    int i;
    int victim;
    bit found;
    res = '{frame: '0, status: ST_FAULT, wb_sector: '0, wb_valid: 1'b0};
    found = 1'b0;
    case (r)
      REQ_LOOKUP: begin
        if (sec_mapped[s]) begin
          res.frame  = sec_frame[s];
          res.status = ST_HIT;
        end else begin
          for (i = 0; i < FRAMES && !found; i++) begin
            if (!frm_used[i]) begin
              link_pair(i, s);
              res.frame  = i[4:0];
              res.status = ST_ALLOC;
              found = 1'b1;
            end
          end
        end
      end
      REQ_REPLACE: begin
        if (sec_mapped[s]) begin
          res.frame  = sec_frame[s];
          res.status = ST_HIT;
        end else begin
          victim = int'(h) % FRAMES;
          if (frm_used[victim]) begin
            res.wb_sector = frm_sector[victim];
            res.wb_valid  = 1'b1;
            sec_mapped[frm_sector[victim]] = 1'b0;
          end
          link_pair(victim, s);
          res.frame  = victim[4:0];
          res.status = ST_REPLACED;
        end
      end
      REQ_FREE: begin
        if (sec_mapped[s]) begin
          res.frame  = sec_frame[s];
          res.status = ST_FREED;
          frm_used[sec_frame[s]] = 1'b0;
          sec_mapped[s] = 1'b0;
        end else begin
          res.status = ST_IGNORED;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic issue_request(req_t r, logic [SEC_W-1:0] s, logic [HINT_W-1:0] h,
                               bit typed, page_result_t want);
    page_result_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, h, s};
    in_tuser  <= r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = map_request(r, s, h);
    pending_results.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    page_result_t got;
    page_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.frame     = out_tdata[4:0];
      got.wb_sector = out_tdata[14:5];
      got.status    = out_tuser[2:0];
      got.wb_valid  = out_tuser[3];
      status_seen[got.status]++;
      if (got.wb_valid) wb_seen++;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: frame %0d status %0d wb %0d/%0b",
                   got.frame, got.status, got.wb_sector, got.wb_valid);
      end else begin
        want = pending_results.pop_front();
        if (got.frame !== want.frame || got.status !== want.status ||
            got.wb_sector !== want.wb_sector || got.wb_valid !== want.wb_valid) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected frame %0d status %0d wb %0d/%0b, got frame %0d status %0d wb %0d/%0b",
                     want.frame, want.status, want.wb_sector, want.wb_valid,
                     got.frame, got.status, got.wb_sector, got.wb_valid);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int i;
    int ph;
    int k;
    int roll;
    int pool_size;
    int drain;
    int phase_src [4];
    int phase_sink [4];
    logic [SEC_W-1:0] pool_base;
    logic [SEC_W-1:0] s;
    req_t r;
    page_result_t none;

    phase_src  = '{0, 81, 0, 38};
    phase_sink = '{0, 0, 81, 38};
    none = '{frame: '0, status: ST_FAULT, wb_sector: '0, wb_valid: 1'b0};
    dir_table = '{
      '{REQ_LOOKUP,  10'd0,    16'h0000, 1'b1, '{5'd0,  ST_ALLOC,    10'd0,    1'b0}},
      '{REQ_LOOKUP,  10'd0,    16'hFFFF, 1'b1, '{5'd0,  ST_HIT,      10'd0,    1'b0}},
      '{REQ_LOOKUP,  10'd1023, 16'h0000, 1'b1, '{5'd1,  ST_ALLOC,    10'd0,    1'b0}},
      '{REQ_REPLACE, 10'd1023, 16'h1234, 1'b1, '{5'd1,  ST_HIT,      10'd0,    1'b0}},
      '{REQ_REPLACE, 10'd5,    16'hFFFF, 1'b1, '{5'd31, ST_REPLACED, 10'd0,    1'b0}},
      '{REQ_REPLACE, 10'd6,    16'h0000, 1'b1, '{5'd0,  ST_REPLACED, 10'd0,    1'b1}},
      '{REQ_REPLACE, 10'd7,    16'h0021, 1'b1, '{5'd1,  ST_REPLACED, 10'd1023, 1'b1}},
      '{REQ_FREE,    10'd0,    16'h0000, 1'b1, '{5'd0,  ST_IGNORED,  10'd0,    1'b0}},
      '{REQ_FREE,    10'd7,    16'hFFFF, 1'b1, '{5'd1,  ST_FREED,    10'd0,    1'b0}},
      '{REQ_UNUSED,  10'd1023, 16'hFFFF, 1'b1, '{5'd0,  ST_FAULT,    10'd0,    1'b0}},
      '{REQ_FREE,    10'd1023, 16'h0000, 1'b1, '{5'd0,  ST_IGNORED,  10'd0,    1'b0}},
      '{REQ_LOOKUP,  10'd1023, 16'h0000, 1'b1, '{5'd1,  ST_ALLOC,    10'd0,    1'b0}},
      '{REQ_REPLACE, 10'h2AA,  16'hAAAA, 1'b1, '{5'd10, ST_REPLACED, 10'd0,    1'b0}},
      '{REQ_REPLACE, 10'h155,  16'h5555, 1'b1, '{5'd21, ST_REPLACED, 10'd0,    1'b0}},
      '{REQ_REPLACE, 10'h3FE,  16'h7FFF, 1'b1, '{5'd31, ST_REPLACED, 10'd5,    1'b1}},
      '{REQ_REPLACE, 10'h001,  16'h8000, 1'b1, '{5'd0,  ST_REPLACED, 10'd6,    1'b1}},
      '{REQ_FREE,    10'h3FE,  16'h0000, 1'b1, '{5'd31, ST_FREED,    10'd0,    1'b0}},
      '{REQ_FREE,    10'h3FE,  16'h0000, 1'b1, '{5'd0,  ST_IGNORED,  10'd0,    1'b0}},
      '{REQ_LOOKUP,  10'h155,  16'h0000, 1'b1, '{5'd21, ST_HIT,      10'd0,    1'b0}},
      '{REQ_UNUSED,  10'd0,    16'h0000, 1'b1, '{5'd0,  ST_FAULT,    10'd0,    1'b0}},
      '{REQ_REPLACE, 10'h200,  16'h0001, 1'b1, '{5'd1,  ST_REPLACED, 10'd1023, 1'b1}},
      '{REQ_LOOKUP,  10'h100,  16'hC3C3, 1'b0, '{5'd0,  ST_FAULT,    10'd0,    1'b0}},
      '{REQ_FREE,    10'h2AA,  16'h3C3C, 1'b0, '{5'd0,  ST_FAULT,    10'd0,    1'b0}}
    };

    for (i = 0; i < FRAMES; i++) frm_used[i] = 1'b0;
    for (i = 0; i < SECTORS; i++) sec_mapped[i] = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++)
      issue_request(dir_table[i].req, dir_table[i].sector, dir_table[i].hint,
                    dir_table[i].typed, dir_table[i].want);

    // random traffic over a sliding working set; wide sets overfill the frames
    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct   = phase_src[ph];
      sink_stall_pct = phase_sink[ph];
      pool_base = '0;
      pool_size = 24;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) begin
          pool_base = SEC_W'($urandom_range(0, SECTORS - 1));
          pool_size = ($urandom_range(0, 1) != 0) ? 48 : 24;
        end
        if ($urandom_range(0, 99) < 85)
          s = pool_base + SEC_W'($urandom_range(0, pool_size - 1));
        else
          s = SEC_W'($urandom_range(0, SECTORS - 1));
        roll = $urandom_range(0, 99);
        if (roll < 45)      r = REQ_LOOKUP;
        else if (roll < 70) r = REQ_REPLACE;
        else if (roll < 95) r = REQ_FREE;
        else                r = REQ_UNUSED;
        issue_request(r, s, HINT_W'($urandom_range(0, 65535)), 1'b0, none);
      end
    end
    in_tvalid <= 1'b0;

    drain = 0;
    while (pending_results.size() != 0 && drain < 50000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    fail_count += pending_results.size();

    $display("covered %0d directed and %0d random requests over four idle/stall phases",
             DIR_ROWS, 4 * PHASE_ITEMS);
    $display("seen: %0d hit, %0d alloc, %0d fault, %0d replace (%0d write-back), %0d freed, %0d ignored",
             status_seen[ST_HIT], status_seen[ST_ALLOC], status_seen[ST_FAULT],
             status_seen[ST_REPLACED], wb_seen, status_seen[ST_FREED],
             status_seen[ST_IGNORED]);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/pfm_pkg.sv
hw/rtl/pfm_mod_unit.sv
hw/rtl/pfm_free_scan.sv
hw/rtl/page_frame_mapper_core.sv
tb/sv/tb.sv
